@@ hdl/mhpq_pkg.sv @@
package mhpq_pkg;

  // Default number of heap slots.
  localparam int HEAP_DEPTH_DEF = 32;

  // Fixed field widths of the stream words.
  localparam int KEY_W   = 32;
  localparam int IDX_W   = 5;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 6;

  // Command codes carried on in_tuser.
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DEL_KEY = 2'd1,
    CMD_DEL_IDX = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  // Status codes carried on out_tuser.
  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_GET_RD,
    S_GET,
    S_SH_RD,
    S_SH_WR,
    S_LAST_RD,
    S_LAST_GET,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_UP_RD,
    S_UP_CMP,
    S_WR_CUR,
    S_DONE
  } state_t;

endpackage

@@ hdl/max_heap_priority_queue.sv @@
// Channel  Direction  Handshake               Payload
// in_      slave      in_tvalid / in_tready   tuser: cmd; tdata: key, index
// out_     master     out_tvalid / out_tready tuser: status; tdata: value, count
//
// One command is worked at a time by a sequencer around a single heap memory
// with one write port and one registered read port.
// Insert climbs the tree level by level; delete-at-index shifts the path above
// the target down to the root, moves the last entry into the root and sifts it down.
// Delete-by-value first scans the entries for the key; read fetches one entry.
// Reset clears the entry count and the control state; the memory is not cleared.
// A finished word waits in the output register while the next command is taken.
module max_heap_priority_queue #(
  parameter int HEAP_DEPTH = mhpq_pkg::HEAP_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  input  logic [39:0] in_tdata,   // [31:0] key, [36:32] index, [39:37] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic [39:0] out_tdata   // [31:0] value, [37:32] count, [39:38] zero
);

  localparam int AW  = $clog2(HEAP_DEPTH);
  localparam int CW  = $clog2(HEAP_DEPTH + 1);
  localparam int CHW = CW + 1;

  // Heap memory with registered read data.
  logic signed [mhpq_pkg::KEY_W-1:0] heap_mem [HEAP_DEPTH];
  logic signed [mhpq_pkg::KEY_W-1:0] rd_data_r;
  logic                              rd_en;
  logic [AW-1:0]                     rd_addr;
  logic                              wr_en;
  logic [AW-1:0]                     wr_addr;
  logic signed [mhpq_pkg::KEY_W-1:0] wr_data;

  // Control and working registers.
  mhpq_pkg::state_t                  state_r, state_nxt;
  logic [CW-1:0]                     cnt_r, cnt_nxt;
  logic [AW-1:0]                     pos_r, pos_nxt;
  logic signed [mhpq_pkg::KEY_W-1:0] cur_r, cur_nxt;
  logic signed [mhpq_pkg::KEY_W-1:0] gone_r, gone_nxt;
  logic signed [mhpq_pkg::KEY_W-1:0] key_r, key_nxt;
  logic signed [mhpq_pkg::KEY_W-1:0] best_val_r, best_val_nxt;
  logic [AW-1:0]                     best_pos_r, best_pos_nxt;
  logic                              moved_r, moved_nxt;
  logic                              r_ok_r, r_ok_nxt;
  mhpq_pkg::cmd_t                    cmd_r, cmd_nxt;
  mhpq_pkg::status_t                 status_r, status_nxt;
  logic [CW-1:0]                     scan_i_r, scan_i_nxt;
  logic                              scan_v_r, scan_v_nxt;
  logic                              found_r, found_nxt;
  logic [AW-1:0]                     hit_r, hit_nxt;

  // Output register.
  logic                                out_valid_r, out_valid_nxt;
  mhpq_pkg::status_t                   out_status_r, out_status_nxt;
  logic signed [mhpq_pkg::KEY_W-1:0]   out_value_r, out_value_nxt;
  logic [mhpq_pkg::COUNT_W-1:0]        out_count_r, out_count_nxt;

  // Input word fields.
  logic signed [mhpq_pkg::KEY_W-1:0] in_key;
  logic [mhpq_pkg::IDX_W-1:0]        in_index;

  // Tree neighbors of the current slot.
  logic [AW-1:0]  parent;
  logic [CHW-1:0] left;
  logic [CHW-1:0] right;

  assign in_key   = in_tdata[31:0];
  assign in_index = in_tdata[36:32];
  assign parent   = (pos_r - AW'(1)) >> 1;
  assign left     = (CHW'(pos_r) << 1) + CHW'(1);
  assign right    = left + CHW'(1);

  assign in_tready  = (state_r == mhpq_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_count_r, out_value_r};

  // Memory ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= heap_mem[rd_addr];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mhpq_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      scan_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      scan_v_r    <= scan_v_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    cur_r        <= cur_nxt;
    gone_r       <= gone_nxt;
    key_r        <= key_nxt;
    best_val_r   <= best_val_nxt;
    best_pos_r   <= best_pos_nxt;
    moved_r      <= moved_nxt;
    r_ok_r       <= r_ok_nxt;
    cmd_r        <= cmd_nxt;
    status_r     <= status_nxt;
    scan_i_r     <= scan_i_nxt;
    found_r      <= found_nxt;
    hit_r        <= hit_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
  end

  // Sequencer: next state, memory accesses and result.
  always_comb begin
    logic                              dn_moved;
    logic [AW-1:0]                     dn_pos;
    logic signed [mhpq_pkg::KEY_W-1:0] dn_val;

    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    cur_nxt        = cur_r;
    gone_nxt       = gone_r;
    key_nxt        = key_r;
    best_val_nxt   = best_val_r;
    best_pos_nxt   = best_pos_r;
    moved_nxt      = moved_r;
    r_ok_nxt       = r_ok_r;
    cmd_nxt        = cmd_r;
    status_nxt     = status_r;
    scan_i_nxt     = scan_i_r;
    scan_v_nxt     = 1'b0;
    found_nxt      = found_r;
    hit_nxt        = hit_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    dn_moved       = moved_r;
    dn_pos         = best_pos_r;
    dn_val         = best_val_r;

    unique case (state_r)
      mhpq_pkg::S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt    = mhpq_pkg::cmd_t'(in_tuser);
          key_nxt    = in_key;
          gone_nxt   = '0;
          status_nxt = mhpq_pkg::ST_OK;
          unique case (mhpq_pkg::cmd_t'(in_tuser))
            mhpq_pkg::CMD_INSERT: begin
              if (cnt_r >= CW'(HEAP_DEPTH)) begin
                status_nxt = mhpq_pkg::ST_FULL;
                state_nxt  = mhpq_pkg::S_DONE;
              end else begin
                cnt_nxt = cnt_r + CW'(1);
                pos_nxt = AW'(cnt_r);
                cur_nxt = in_key;
                if (cnt_r == '0) begin
                  wr_en     = 1'b1;
                  wr_addr   = '0;
                  wr_data   = in_key;
                  state_nxt = mhpq_pkg::S_DONE;
                end else begin
                  state_nxt = mhpq_pkg::S_UP_RD;
                end
              end
            end
            mhpq_pkg::CMD_DEL_KEY: begin
              if (cnt_r == '0) begin
                status_nxt = mhpq_pkg::ST_MISSING;
                state_nxt  = mhpq_pkg::S_DONE;
              end else begin
                scan_i_nxt = '0;
                found_nxt  = 1'b0;
                state_nxt  = mhpq_pkg::S_SCAN;
              end
            end
            default: begin
              if (cnt_r == '0) begin
                status_nxt = mhpq_pkg::ST_MISSING;
                state_nxt  = mhpq_pkg::S_DONE;
              end else if (32'(in_index) >= 32'(cnt_r)) begin
                status_nxt = mhpq_pkg::ST_RANGE;
                state_nxt  = mhpq_pkg::S_DONE;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = AW'(in_index);
                pos_nxt   = AW'(in_index);
                state_nxt = mhpq_pkg::S_GET;
              end
            end
          endcase
        end
      end

      // Linear search, one read issued and one compare done per cycle.
      mhpq_pkg::S_SCAN: begin
        if (scan_v_r && rd_data_r == key_r) begin
          found_nxt = 1'b1;
          hit_nxt   = AW'(scan_i_r - CW'(1));
        end
        if (scan_i_r < cnt_r) begin
          rd_en      = 1'b1;
          rd_addr    = AW'(scan_i_r);
          scan_v_nxt = 1'b1;
          scan_i_nxt = scan_i_r + CW'(1);
        end else if (!scan_v_r) begin
          if (found_r) begin
            pos_nxt   = hit_r;
            state_nxt = mhpq_pkg::S_GET_RD;
          end else begin
            status_nxt = mhpq_pkg::ST_MISSING;
            state_nxt  = mhpq_pkg::S_DONE;
          end
        end
      end

      mhpq_pkg::S_GET_RD: begin
        rd_en     = 1'b1;
        rd_addr   = pos_r;
        state_nxt = mhpq_pkg::S_GET;
      end

      // The target entry is in the read register.
      mhpq_pkg::S_GET: begin
        gone_nxt = rd_data_r;
        if (cmd_r == mhpq_pkg::CMD_READ) begin
          state_nxt = mhpq_pkg::S_DONE;
        end else if (pos_r == '0) begin
          state_nxt = mhpq_pkg::S_LAST_RD;
        end else begin
          state_nxt = mhpq_pkg::S_SH_RD;
        end
      end

      // Shift the path above the target down by one level.
      mhpq_pkg::S_SH_RD: begin
        rd_en     = 1'b1;
        rd_addr   = parent;
        state_nxt = mhpq_pkg::S_SH_WR;
      end

      mhpq_pkg::S_SH_WR: begin
        wr_en   = 1'b1;
        wr_addr = pos_r;
        wr_data = rd_data_r;
        pos_nxt = parent;
        if (parent == '0) begin
          state_nxt = mhpq_pkg::S_LAST_RD;
        end else begin
          state_nxt = mhpq_pkg::S_SH_RD;
        end
      end

      // Fetch the last entry; it fills the root hole.
      mhpq_pkg::S_LAST_RD: begin
        rd_en     = 1'b1;
        rd_addr   = AW'(cnt_r - CW'(1));
        cnt_nxt   = cnt_r - CW'(1);
        state_nxt = mhpq_pkg::S_LAST_GET;
      end

      mhpq_pkg::S_LAST_GET: begin
        cur_nxt   = rd_data_r;
        pos_nxt   = '0;
        state_nxt = mhpq_pkg::S_DN_L;
      end

      // Sift down: read the left child if present.
      mhpq_pkg::S_DN_L: begin
        if (left < CHW'(cnt_r)) begin
          rd_en     = 1'b1;
          rd_addr   = AW'(left);
          state_nxt = mhpq_pkg::S_DN_R;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = pos_r;
          wr_data   = cur_r;
          state_nxt = mhpq_pkg::S_DONE;
        end
      end

      // Compare the left child; read the right child if present.
      mhpq_pkg::S_DN_R: begin
        if (rd_data_r > cur_r) begin
          best_val_nxt = rd_data_r;
          best_pos_nxt = AW'(left);
          moved_nxt    = 1'b1;
        end else begin
          best_val_nxt = cur_r;
          best_pos_nxt = pos_r;
          moved_nxt    = 1'b0;
        end
        if (right < CHW'(cnt_r)) begin
          rd_en    = 1'b1;
          rd_addr  = AW'(right);
          r_ok_nxt = 1'b1;
        end else begin
          r_ok_nxt = 1'b0;
        end
        state_nxt = mhpq_pkg::S_DN_CMP;
      end

      // Pick the larger child, left wins a tie, and move it up.
      mhpq_pkg::S_DN_CMP: begin
        if (r_ok_r && rd_data_r > best_val_r) begin
          dn_moved = 1'b1;
          dn_pos   = AW'(right);
          dn_val   = rd_data_r;
        end
        wr_en   = 1'b1;
        wr_addr = pos_r;
        if (dn_moved) begin
          wr_data   = dn_val;
          pos_nxt   = dn_pos;
          state_nxt = mhpq_pkg::S_DN_L;
        end else begin
          wr_data   = cur_r;
          state_nxt = mhpq_pkg::S_DONE;
        end
      end

      // Sift up: pull smaller parents down into the hole.
      mhpq_pkg::S_UP_RD: begin
        rd_en     = 1'b1;
        rd_addr   = parent;
        state_nxt = mhpq_pkg::S_UP_CMP;
      end

      mhpq_pkg::S_UP_CMP: begin
        wr_en   = 1'b1;
        wr_addr = pos_r;
        if (rd_data_r < cur_r) begin
          wr_data = rd_data_r;
          pos_nxt = parent;
          if (parent == '0) begin
            state_nxt = mhpq_pkg::S_WR_CUR;
          end else begin
            state_nxt = mhpq_pkg::S_UP_RD;
          end
        end else begin
          wr_data   = cur_r;
          state_nxt = mhpq_pkg::S_DONE;
        end
      end

      mhpq_pkg::S_WR_CUR: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r;
        wr_data   = cur_r;
        state_nxt = mhpq_pkg::S_DONE;
      end

      // Hand the word to the output register once it is free.
      mhpq_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_value_nxt  = gone_r;
          out_count_nxt  = mhpq_pkg::COUNT_W'(cnt_r);
          state_nxt      = mhpq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = mhpq_pkg::S_IDLE;
      end
    endcase
  end

  // The entry count never passes the depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= HEAP_DEPTH)
    else $error("entry count above heap depth");

  // Memory writes stay inside the heap.
  a_wr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> 32'(wr_addr) < HEAP_DEPTH)
    else $error("heap write outside the memory");

  // No read and write of the same slot in one cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> rd_addr != wr_addr)
    else $error("read and write of one slot in the same cycle");

  // An accepted word starts work on the sequencer.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r != mhpq_pkg::S_IDLE)
    else $error("sequencer idle after accepting a word");

  // A failed command returns a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != mhpq_pkg::ST_OK) |-> out_value_r == '0)
    else $error("nonzero value with an error status");

endmodule

@@ test/tb_max_heap_priority_queue.sv @@
`timescale 1ns / 1ps

module tb_max_heap_priority_queue;

  localparam int DEPTH = mhpq_pkg::HEAP_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 360;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic [5:0]  count;
  } heap_result_t;

  typedef struct {
    mhpq_pkg::cmd_t cmd;
    logic [31:0]    key;
    logic [4:0]     index;
    bit             known;
    heap_result_t   want;
  } heap_cmd_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [1:0]  out_tuser;
  logic [39:0] out_tdata;

  // Shadow heap and the queue of results it predicts.
  logic signed [31:0] shadow_heap [DEPTH];
  int unsigned        shadow_count = 0;
  heap_result_t       pending_results [$];
  heap_cmd_t          table_rows [$];
  int                 fail_count = 0;
  int unsigned        cycle_count = 0;

  max_heap_priority_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tuser(out_tuser), .out_tdata(out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sift the entry at pos down, taking the strictly larger child (left wins ties).
  function automatic void shadow_sift_down(int unsigned pos);
    int unsigned l, r, best;
    logic signed [31:0] t;
    forever begin
      l = 2 * pos + 1;
      r = l + 1;
      best = pos;
      if (l < shadow_count && shadow_heap[l] > shadow_heap[best]) best = l;
      if (r < shadow_count && shadow_heap[r] > shadow_heap[best]) best = r;
      if (best == pos) return;
      t = shadow_heap[best];
      shadow_heap[best] = shadow_heap[pos];
      shadow_heap[pos] = t;
      pos = best;
    end
  endfunction

  // Lift the target to the root, replace the root with the last entry, sift down.
  function automatic logic [31:0] shadow_remove(int unsigned pos);
    logic [31:0] gone;
    gone = shadow_heap[pos];
    while (pos > 0) begin
      shadow_heap[pos] = shadow_heap[(pos - 1) / 2];
      pos = (pos - 1) / 2;
    end
    shadow_heap[0] = shadow_heap[shadow_count - 1];
    shadow_count--;
    shadow_sift_down(0);
    return gone;
  endfunction

  // Apply one command to the shadow heap and return the word it should produce.
  function automatic heap_result_t heap_apply(mhpq_pkg::cmd_t cmd, logic signed [31:0] key,
                                              logic [4:0] index);
    heap_result_t res;
    int unsigned pos;
    int hit;
    logic signed [31:0] t;
    res.status = mhpq_pkg::ST_OK;
    res.value = '0;
    case (cmd)
      mhpq_pkg::CMD_INSERT: begin
        if (shadow_count >= DEPTH) begin
          res.status = mhpq_pkg::ST_FULL;
        end else begin
          pos = shadow_count;
          shadow_heap[pos] = key;
          shadow_count++;
          while (pos > 0 && shadow_heap[(pos - 1) / 2] < shadow_heap[pos]) begin
            t = shadow_heap[(pos - 1) / 2];
            shadow_heap[(pos - 1) / 2] = shadow_heap[pos];
            shadow_heap[pos] = t;
            pos = (pos - 1) / 2;
          end
        end
      end
      mhpq_pkg::CMD_DEL_KEY: begin
        hit = -1;
        for (int i = 0; i < shadow_count; i++)
          if (shadow_heap[i] == key) hit = i;
        if (hit < 0) res.status = mhpq_pkg::ST_MISSING;
        else res.value = shadow_remove(hit);
      end
      default: begin
        if (shadow_count == 0) res.status = mhpq_pkg::ST_MISSING;
        else if (index >= shadow_count) res.status = mhpq_pkg::ST_RANGE;
        else if (cmd == mhpq_pkg::CMD_DEL_IDX) res.value = shadow_remove(index);
        else res.value = shadow_heap[index];
      end
    endcase
    res.count = shadow_count[5:0];
    return res;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(heap_cmd_t row);
    table_rows.insert(table_rows.size(), row);
  endfunction

  // Random gap: mostly short, now and then long.
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Send one word and queue its expected result. tvalid stays high on return,
  // so the caller either sends the next word at once or pauses.
  task automatic send_cmd(heap_cmd_t c);
    heap_result_t res;
    res = heap_apply(c.cmd, c.key, c.index);
    if (c.known && res != c.want) begin
      $display("%0t directed row disagrees: expected %h predicted %h", $time, c.want, res);
      fail_count++;
    end
    pending_results.insert(pending_results.size(), res);
    in_tvalid <= 1'b1;
    in_tuser  <= c.cmd;
    in_tdata  <= {3'b000, c.index, c.key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop tvalid for a number of cycles; zero keeps the words back to back.
  task automatic pause(int cycles);
    if (cycles > 0) begin
      in_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Random command with bias toward the current heap contents.
  function automatic heap_cmd_t random_cmd();
    heap_cmd_t c;
    int roll;
    c.known = 1'b0;
    c.want = '0;
    c.index = (shadow_count > 0 && $urandom_range(0, 3) != 0) ?
              5'($urandom_range(0, shadow_count - 1)) : 5'($urandom);
    roll = $urandom_range(0, 2);
    if (roll == 0) c.key = $urandom;
    else if (roll == 1) c.key = 32'($signed($urandom_range(0, 15)) - 8);
    else c.key = (shadow_count > 0) ? shadow_heap[$urandom_range(0, shadow_count - 1)]
                                    : $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 40) c.cmd = mhpq_pkg::CMD_INSERT;
    else if (roll < 60) c.cmd = mhpq_pkg::CMD_DEL_KEY;
    else if (roll < 78) c.cmd = mhpq_pkg::CMD_DEL_IDX;
    else c.cmd = mhpq_pkg::CMD_READ;
    return c;
  endfunction

  // Stimulus: directed table, then random commands.
  initial begin
    heap_cmd_t c;
    int n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty heap errors, extremes of the key, ties, and a drain.
    add_row('{mhpq_pkg::CMD_READ,    32'd0,        5'd0,  1'b1,
              '{mhpq_pkg::ST_MISSING, 32'd0, 6'd0}});
    add_row('{mhpq_pkg::CMD_DEL_IDX, 32'd0,        5'd31, 1'b1,
              '{mhpq_pkg::ST_MISSING, 32'd0, 6'd0}});
    add_row('{mhpq_pkg::CMD_DEL_KEY, 32'h7fffffff, 5'd0,  1'b1,
              '{mhpq_pkg::ST_MISSING, 32'd0, 6'd0}});
    add_row('{mhpq_pkg::CMD_INSERT,  32'h80000000, 5'd31, 1'b1,
              '{mhpq_pkg::ST_OK, 32'd0, 6'd1}});
    add_row('{mhpq_pkg::CMD_INSERT,  32'h7fffffff, 5'd0,  1'b1,
              '{mhpq_pkg::ST_OK, 32'd0, 6'd2}});
    add_row('{mhpq_pkg::CMD_READ,    32'd0,        5'd0,  1'b1,
              '{mhpq_pkg::ST_OK, 32'h7fffffff, 6'd2}});
    add_row('{mhpq_pkg::CMD_READ,    32'hffffffff, 5'd2,  1'b1,
              '{mhpq_pkg::ST_RANGE, 32'd0, 6'd2}});
    add_row('{mhpq_pkg::CMD_READ,    32'd0,        5'd31, 1'b1,
              '{mhpq_pkg::ST_RANGE, 32'd0, 6'd2}});
    add_row('{mhpq_pkg::CMD_INSERT,  32'h7fffffff, 5'd0,  1'b0, '0});
    add_row('{mhpq_pkg::CMD_INSERT,  32'h00000005, 5'd0,  1'b0, '0});
    add_row('{mhpq_pkg::CMD_INSERT,  32'h00000005, 5'd0,  1'b0, '0});
    add_row('{mhpq_pkg::CMD_DEL_IDX, 32'd0,        5'd3,  1'b0, '0});
    add_row('{mhpq_pkg::CMD_DEL_KEY, 32'h00000005, 5'd0,  1'b0, '0});
    add_row('{mhpq_pkg::CMD_DEL_KEY, 32'h00000006, 5'd0,  1'b0, '0});
    add_row('{mhpq_pkg::CMD_DEL_KEY, 32'h80000000, 5'd0,  1'b0, '0});
    add_row('{mhpq_pkg::CMD_DEL_IDX, 32'd0,        5'd0,  1'b0, '0});
    add_row('{mhpq_pkg::CMD_DEL_IDX, 32'd0,        5'd0,  1'b0, '0});
    foreach (table_rows[i]) begin
      send_cmd(table_rows[i]);
      pause(gap_len());
    end

    // Fill to full, then insert on a full heap.
    c.known = 1'b0;
    c.want = '0;
    c.index = 5'd31;
    for (int i = 0; i < DEPTH + 2; i++) begin
      c.cmd = mhpq_pkg::CMD_INSERT;
      c.key = (i % 3 == 0) ? 32'd7 : $urandom;
      send_cmd(c);
    end
    c.cmd = mhpq_pkg::CMD_READ;
    c.index = 5'd31;
    send_cmd(c);

    // Hold off until the block has caught up.
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    n = 0;
    while (n < RANDOM_ITEMS) begin
      c = random_cmd();
      send_cmd(c);
      n++;
      // Now and then drive the heap to full or to empty.
      if (n % 150 == 75) begin
        while (shadow_count < DEPTH) begin
          c.cmd = mhpq_pkg::CMD_INSERT;
          c.key = $urandom;
          send_cmd(c);
        end
        c.cmd = mhpq_pkg::CMD_INSERT;
        c.key = $urandom;
        send_cmd(c);
      end else if (n % 150 == 0) begin
        while (shadow_count > 0) begin
          c.cmd = mhpq_pkg::CMD_DEL_IDX;
          c.index = 5'($urandom_range(0, shadow_count - 1));
          send_cmd(c);
        end
      end
      if ((n / 60) % 2 == 0) pause(gap_len());
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result side stalls.
  initial begin
    int hold;
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      @(posedge clk);
      hold = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    heap_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[31:0], out_tdata[37:32]};
      if (pending_results.size() == 0) begin
        $display("%0t unexpected word: expected none actual %h", $time, got);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $display("%0t status: expected %0d actual %0d", $time, want.status, got.status);
          fail_count++;
        end
        if (got.value !== want.value) begin
          $display("%0t value: expected %h actual %h", $time, want.value, got.value);
          fail_count++;
        end
        if (got.count !== want.count) begin
          $display("%0t count: expected %0d actual %0d", $time, want.count, got.count);
          fail_count++;
        end
      end
    end
  end

  // Timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule

@@ max_heap_priority_queue.f @@
hdl/mhpq_pkg.sv
hdl/max_heap_priority_queue.sv
test/tb_max_heap_priority_queue.sv
